@@ src/bmrf_pkg.sv @@
// ----------------------------------------------------------------------------
// bmrf_pkg
// Shared types and fixed widths of the bitmap rectangle fill counter.
// ----------------------------------------------------------------------------
package bmrf_pkg;

  localparam int COORD_W = 11;  // corner coordinate width
  localparam int CFG_W   = 11;  // grid_size register width
  localparam int CNT_W   = 21;  // white_count width

  typedef enum logic [3:0] {
    S_FILL,
    S_IDLE,
    S_PREP,
    S_SPLIT,
    S_PAINT,
    S_PDRAIN,
    S_COUNT,
    S_CDRAIN,
    S_DONE
  } state_t;

endpackage

@@ src/bmrf_mem.sv @@
// ----------------------------------------------------------------------------
// bmrf_mem
// Simple dual-port bitmap store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bmrf_mem #(
  parameter int AW = 14,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  // Read returns the old word when both ports hit the same entry.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/bmrf_cnt.sv @@
// ----------------------------------------------------------------------------
// bmrf_cnt
// Two-stage population count and accumulator for the white-cell total.
// ----------------------------------------------------------------------------
module bmrf_cnt
  import bmrf_pkg::*;
#(
  parameter int WB = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic             in_valid,
  input  logic [WB-1:0]    in_data,
  output logic [CNT_W-1:0] total
);

  localparam int PW = $clog2(WB + 1);

  logic [PW-1:0] pop_next;
  logic [PW-1:0] pop;
  logic          pop_valid;

  always_comb begin
    pop_next = '0;
    for (int i = 0; i < WB; i++) begin
      pop_next = pop_next + PW'(in_data[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      pop_valid <= 1'b0;
      total     <= '0;
    end else begin
      pop_valid <= in_valid;
      if (pop_valid) begin
        total <= total + CNT_W'(pop);
      end
    end
  end

  always_ff @(posedge clk) begin
    pop <= pop_next;
  end

endmodule

@@ src/bitmap_rectangle_fill_count.sv @@
// ----------------------------------------------------------------------------
// bitmap_rectangle_fill_count
// Paints rectangles into a one-bit-per-cell bitmap and counts white cells.
// ----------------------------------------------------------------------------
// Paint: PREP, SPLIT, then one word touched per cycle (rows x words), then PDRAIN.
// A last item adds a count sweep over all 2**AW words (16384 by default) and
// CDRAIN; the sweep also restores the all-white pattern. Result strobe is 1 cycle.
// One item at a time: busy stays high until the item's work is done.
// Reset and every grid_size write run a clearing pass of all 2**AW words, busy high.
// The receiver cannot stall; done is a single-cycle strobe.
module bitmap_rectangle_fill_count
  import bmrf_pkg::*;
#(
  parameter int GRID_MAX  = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [COORD_W-1:0] row_a,
  input  logic [COORD_W-1:0] col_a,
  input  logic [COORD_W-1:0] row_b,
  input  logic [COORD_W-1:0] col_b,
  input  logic               colour,
  input  logic               last,
  output logic               done,
  output logic [CNT_W-1:0]   white_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_W-1:0]   grid_size
);

  localparam int WB  = WORD_BITS;
  localparam int RW  = (GRID_MAX + WB - 1) / WB;        // words per row
  localparam int WW  = (RW > 1) ? $clog2(RW) : 1;       // word index width
  localparam int RB  = $clog2(GRID_MAX);                // row / column index width
  localparam int AW  = RB + WW;                         // memory address width
  localparam int BW  = $clog2(WB);                      // bit index width
  localparam int SW  = ($clog2(GRID_MAX + 1) > CFG_W) ? $clog2(GRID_MAX + 1) : CFG_W;
  localparam int LW  = SW + 2;                          // column offset of a word
  localparam int KSH = 24;                              // reciprocal scale
  localparam int RCW = KSH + 1;
  localparam logic [RCW-1:0] RECIP = RCW'(((1 << KSH) + WB - 1) / WB);
  localparam logic [WB-1:0]  ONES  = {WB{1'b1}};

  state_t state, state_next;

  // Configuration and effective size
  logic [CFG_W-1:0] size_reg;
  logic [SW-1:0]    n_eff;
  logic             cfg_wr;

  // Rectangle of the current item
  logic [RB-1:0] r1, r2, c1, c2;
  logic [WW-1:0] w1, w2;
  logic [BW-1:0] b1, b2;
  logic          white;
  logic          last_q;

  // Walk position
  logic [RB-1:0] row;
  logic [WW-1:0] wcol;
  logic [AW-1:0] addr_cnt;

  // Read-modify-write stage
  logic          p_valid;
  logic [AW-1:0] p_addr;
  logic [WB-1:0] p_mask;
  logic [WB-1:0] mask_next;

  // Count pipeline
  logic rd_valid;
  logic drain;

  // Memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WB-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [WB-1:0] mem_rdata;

  // All-white pattern of the word at addr_cnt
  logic [LW-1:0] fill_lo;
  logic [LW-1:0] fill_cnt;
  logic [WB-1:0] fill_mask;

  // Clamped, zero-based corners
  logic [RB-1:0] ra_i, rb_i, ca_i, cb_i;

  // Column split by reciprocal multiply
  logic [RB+RCW-1:0] q1_prod, q2_prod;

  logic [BW-1:0] lo_bit, hi_bit;

  function automatic logic [RB-1:0] clamp_idx(input logic [COORD_W-1:0] v,
                                              input logic [SW-1:0] n);
    logic [SW-1:0] x;
    x = SW'(v);
    if (x == '0) begin
      x = SW'(1);
    end
    if (x > n) begin
      x = n;
    end
    return RB'(x - SW'(1));
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);

  always_comb begin
    if (size_reg == '0) begin
      n_eff = SW'(1);
    end else if (SW'(size_reg) > SW'(GRID_MAX)) begin
      n_eff = SW'(GRID_MAX);
    end else begin
      n_eff = SW'(size_reg);
    end
  end

  assign ra_i = clamp_idx(row_a, n_eff);
  assign rb_i = clamp_idx(row_b, n_eff);
  assign ca_i = clamp_idx(col_a, n_eff);
  assign cb_i = clamp_idx(col_b, n_eff);

  // Word index = column / WB, exact for every column below GRID_MAX
  assign q1_prod = (RB + RCW)'(c1) * (RB + RCW)'(RECIP);
  assign q2_prod = (RB + RCW)'(c2) * (RB + RCW)'(RECIP);

  // Fill pattern: ones for columns below the size, rows below the size
  always_comb begin
    fill_lo   = LW'(int'(addr_cnt[WW-1:0]) * WB);
    fill_cnt  = LW'(n_eff) - fill_lo;
    fill_mask = '0;
    if ((SW'(addr_cnt[AW-1:WW]) < n_eff) && (fill_lo < LW'(n_eff))) begin
      if (fill_cnt >= LW'(WB)) begin
        fill_mask = ONES;
      end else begin
        fill_mask = ONES >> (LW'(WB) - fill_cnt);
      end
    end
  end

  // Paint mask of the word at {row, wcol}: partial on the first and last word
  always_comb begin
    lo_bit    = (wcol == w1) ? b1 : '0;
    hi_bit    = (wcol == w2) ? b2 : BW'(WB - 1);
    mask_next = (ONES >> (BW'(WB - 1) - hi_bit)) & (ONES << lo_bit);
  end

  // Memory port selection: paint write-back beats the sweep
  always_comb begin
    mem_raddr = (state == S_COUNT) ? addr_cnt : {row, wcol};
    mem_we    = p_valid || (state == S_FILL) || (state == S_COUNT);
    mem_waddr = p_valid ? p_addr : addr_cnt;
    if (p_valid) begin
      mem_wdata = white ? (mem_rdata | p_mask) : (mem_rdata & ~p_mask);
    end else begin
      mem_wdata = fill_mask;
    end
  end

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_FILL: begin
        if (&addr_cnt) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_PREP;
        end
      end
      S_PREP:  state_next = S_SPLIT;
      S_SPLIT: state_next = S_PAINT;
      S_PAINT: begin
        if ((row == r2) && (wcol == w2)) begin
          state_next = S_PDRAIN;
        end
      end
      // Drain state, so the final write lands before the sweep reads it
      S_PDRAIN: state_next = last_q ? S_COUNT : S_IDLE;
      S_COUNT: begin
        if (&addr_cnt) begin
          state_next = S_CDRAIN;
        end
      end
      S_CDRAIN: begin
        if (drain) begin
          state_next = S_DONE;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_FILL;
    endcase
    // A size write restarts the clearing pass
    if (cfg_wr) begin
      state_next = S_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_FILL;
      size_reg <= CFG_W'(1024);
      addr_cnt <= '0;
      p_valid  <= 1'b0;
      rd_valid <= 1'b0;
      drain    <= 1'b0;
    end else begin
      state    <= state_next;
      p_valid  <= (state == S_PAINT) && !cfg_wr;
      rd_valid <= (state == S_COUNT) && !cfg_wr;
      drain    <= (state == S_CDRAIN) && !drain;
      if (cfg_wr) begin
        size_reg <= grid_size;
        addr_cnt <= '0;
      end else if ((state == S_FILL) || (state == S_COUNT)) begin
        addr_cnt <= addr_cnt + AW'(1);
      end
    end
  end

  // Item datapath: latch corners, split columns, walk rows and words
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        r1     <= (ra_i < rb_i) ? ra_i : rb_i;
        r2     <= (ra_i < rb_i) ? rb_i : ra_i;
        c1     <= (ca_i < cb_i) ? ca_i : cb_i;
        c2     <= (ca_i < cb_i) ? cb_i : ca_i;
        white  <= colour;
        last_q <= last;
      end
      S_PREP: begin
        w1 <= q1_prod[KSH +: WW];
        w2 <= q2_prod[KSH +: WW];
      end
      S_SPLIT: begin
        b1   <= BW'(c1 - RB'(int'(w1) * WB));
        b2   <= BW'(c2 - RB'(int'(w2) * WB));
        row  <= r1;
        wcol <= w1;
      end
      S_PAINT: begin
        if (wcol == w2) begin
          wcol <= w1;
          row  <= row + RB'(1);
        end else begin
          wcol <= wcol + WW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Write-back address and mask follow the read into the next cycle
  always_ff @(posedge clk) begin
    p_addr <= {row, wcol};
    p_mask <= mask_next;
  end

  bmrf_mem #(
    .AW (AW),
    .DW (WB)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bmrf_cnt #(
    .WB (WB)
  ) u_cnt (
    .clk      (clk),
    .rst      (rst),
    .clr      (state == S_PDRAIN),
    .in_valid (rd_valid),
    .in_data  (mem_rdata),
    .total    (white_count)
  );

`ifndef ASSERT_OFF
  a_done_single : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe longer than one cycle");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cfg_wr) |=> busy)
    else $error("accepted item did not raise busy");

  a_idle_no_wb : assert property (@(posedge clk) disable iff (rst)
    !busy |-> !p_valid)
    else $error("paint write-back pending while idle");

  a_sweep_same : assert property (@(posedge clk) disable iff (rst)
    (state == S_COUNT && !p_valid) |-> (mem_we && (mem_waddr == mem_raddr)))
    else $error("count sweep read and refill addresses differ");

  a_done_after_count : assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_CDRAIN))
    else $error("result strobe without a finished count");
`endif

endmodule

@@ bench/bitmap_rectangle_fill_count_check.sv @@
// ----------------------------------------------------------------------------
// bitmap_rectangle_fill_count_check
// Watches the paint, count and grid_size channels, predicts each white-cell
// count from its own copy of the bitmap and compares every count transfer.
// ----------------------------------------------------------------------------
module bitmap_rectangle_fill_count_check
  import bmrf_pkg::*;
#(
  parameter int GRID_MAX  = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [COORD_W-1:0] row_a,
  input  logic [COORD_W-1:0] col_a,
  input  logic [COORD_W-1:0] row_b,
  input  logic [COORD_W-1:0] col_b,
  input  logic               colour,
  input  logic               last,
  input  logic               done,
  input  logic [CNT_W-1:0]   white_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_W-1:0]   grid_size,
  output int                 pending,
  output int                 fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_WORDS = (GRID_MAX + WORD_BITS - 1) / WORD_BITS;

  typedef bit [WORD_BITS-1:0] word_t;

  word_t            cells [GRID_MAX][ROW_WORDS];
  logic [CFG_W-1:0] size_reg;
  int unsigned      side;
  logic [CNT_W-1:0] white_q [$];
  logic [CNT_W-1:0] want;
  int unsigned      ra, ca, rb, cb, r1, r2, c1, c2, w1, w2, lo, hi, whites;
  word_t            mask;
  int               mismatches = 0;

  assign fail_count = mismatches;

  function automatic word_t ones_below(int unsigned k);
    if (k >= WORD_BITS) return '1;
    return (word_t'(1) << k) - word_t'(1);
  endfunction

  function automatic int unsigned clip(logic [COORD_W-1:0] v, int unsigned n);
    int unsigned x;
    x = v;
    if (x < 1) x = 1;
    if (x > n) x = n;
    return x;
  endfunction

  // Restore all white inside the effective grid, zero outside it.
  task automatic whiten();
    int unsigned base;
    if (size_reg < 1) side = 1;
    else if (size_reg > GRID_MAX) side = GRID_MAX;
    else side = size_reg;
    for (int r = 0; r < GRID_MAX; r++) begin
      for (int w = 0; w < ROW_WORDS; w++) begin
        base = w * WORD_BITS;
        if (r < side && base < side) cells[r][w] = ones_below(side - base);
        else cells[r][w] = '0;
      end
    end
  endtask

  task automatic report(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      size_reg = CFG_W'(1024);
      whiten();
      white_q.delete();
    end else begin
      // Count transfer: compare with the oldest prediction.
      if (done) begin
        if (white_q.size() == 0) begin
          report($sformatf("white_count %0d with no count pending", white_count));
        end else begin
          want = white_q.pop_front();
          if (white_count !== want)
            report($sformatf("white_count %0d, predicted %0d", white_count, want));
        end
      end

      // Paint transfer: apply the rectangle, then count and restore on last.
      if (start && !busy) begin
        ra = clip(row_a, side);
        ca = clip(col_a, side);
        rb = clip(row_b, side);
        cb = clip(col_b, side);
        r1 = ((ra < rb) ? ra : rb) - 1;
        r2 = ((ra < rb) ? rb : ra) - 1;
        c1 = ((ca < cb) ? ca : cb) - 1;
        c2 = ((ca < cb) ? cb : ca) - 1;
        w1 = c1 / WORD_BITS;
        w2 = c2 / WORD_BITS;
        for (int unsigned r = r1; r <= r2; r++) begin
          for (int unsigned w = w1; w <= w2; w++) begin
            lo   = (w == w1) ? c1 % WORD_BITS : 0;
            hi   = (w == w2) ? c2 % WORD_BITS : WORD_BITS - 1;
            mask = ones_below(hi + 1) & ~ones_below(lo);
            if (colour) cells[r][w] |= mask;
            else cells[r][w] &= ~mask;
          end
        end
        if (last) begin
          whites = 0;
          for (int r = 0; r < side; r++)
            for (int w = 0; w < ROW_WORDS; w++)
              whites += $countones(cells[r][w]);
          white_q.push_back(CNT_W'(whites));
          whiten();
        end
      end

      // A grid_size write starts a fresh job at the new size.
      if (cfg_valid && cfg_ready) begin
        size_reg = grid_size;
        whiten();
      end
    end
    pending <= white_q.size();
  end

endmodule

@@ bench/bitmap_rectangle_fill_count_test.sv @@
// ----------------------------------------------------------------------------
// bitmap_rectangle_fill_count_test
// Drives rectangle paints and grid_size writes into the fill counter: a
// directed pass over corners, word edges and size extremes, then random jobs
// at mostly small grid sizes; the checker beside the block judges the counts.
// ----------------------------------------------------------------------------
module bitmap_rectangle_fill_count_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bmrf_pkg::*;

  localparam int GRID_MAX   = 1024;
  localparam int WORD_BITS  = 64;
  // The limit covers the worst stretch (a full-grid paint plus a count
  // sweep, or a clearing pass) with margin.
  localparam int HOLD_LIMIT = 150000;
  localparam int RANDOM_ITEMS = 84;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               busy;
  logic [COORD_W-1:0] row_a       = '0;
  logic [COORD_W-1:0] col_a       = '0;
  logic [COORD_W-1:0] row_b       = '0;
  logic [COORD_W-1:0] col_b       = '0;
  logic               colour      = 1'b0;
  logic               last        = 1'b0;
  logic               done;
  logic [CNT_W-1:0]   white_count;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   grid_size   = '0;

  int          pending;
  int          fail_count;
  int          idle_cycles  = 0;
  int          random_sent  = 0;
  int unsigned side_now     = GRID_MAX;

  always #10 clk = ~clk;

  bitmap_rectangle_fill_count #(
    .GRID_MAX  (GRID_MAX),
    .WORD_BITS (WORD_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .row_a       (row_a),
    .col_a       (col_a),
    .row_b       (row_b),
    .col_b       (col_b),
    .colour      (colour),
    .last        (last),
    .done        (done),
    .white_count (white_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .grid_size   (grid_size)
  );

  bitmap_rectangle_fill_count_check #(
    .GRID_MAX  (GRID_MAX),
    .WORD_BITS (WORD_BITS)
  ) u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .row_a       (row_a),
    .col_a       (col_a),
    .row_b       (row_b),
    .col_b       (col_b),
    .colour      (colour),
    .last        (last),
    .done        (done),
    .white_count (white_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .grid_size   (grid_size),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  // Watchdog: any transfer on any channel restarts the count of quiet cycles.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HOLD_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one paint item after a gap and hold it until the block takes it.
  // Leave start high afterwards, so a following item with no gap keeps the
  // strobe up without a drop inside the same time step.
  task automatic send(input int unsigned ra, ca, rb, cb, input bit col, lst,
                      input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    row_a  <= ra[COORD_W-1:0];
    col_a  <= ca[COORD_W-1:0];
    row_b  <= rb[COORD_W-1:0];
    col_b  <= cb[COORD_W-1:0];
    colour <= col;
    last   <= lst;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold off until every count is in and the block is idle.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // Write grid_size only from idle; track the effective side for stimulus.
  task automatic write_size(input int unsigned v);
    logic [CFG_W-1:0] raw;
    raw = v[CFG_W-1:0];
    settle();
    cfg_valid <= 1'b1;
    grid_size <= raw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (raw < 1) side_now = 1;
    else if (raw > GRID_MAX) side_now = GRID_MAX;
    else side_now = raw;
  endtask

  // One corner coordinate: mostly inside the grid, sometimes at or past the
  // edges, sometimes anywhere in the 11-bit field.
  function automatic int unsigned corner(int unsigned n);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, (1 << COORD_W) - 1);
      1:       return 0;
      2:       return n;
      3:       return n + 1;
      default: return $urandom_range(1, n);
    endcase
  endfunction

  // Partner corner close to v, for cheap rectangles on large grids.
  function automatic int unsigned nearby(int unsigned v);
    int x;
    x = int'(v) + int'($urandom_range(0, 48)) - 24;
    if (x < 0) x = 0;
    if (x > (1 << COORD_W) - 1) x = (1 << COORD_W) - 1;
    return x;
  endfunction

  task automatic random_item(input int gap);
    int unsigned ra, ca, rb, cb;
    ra = corner(side_now);
    ca = corner(side_now);
    // Keep rectangles small on large grids, except for an odd wide one.
    if (side_now <= 128 || $urandom_range(0, 15) == 0) begin
      rb = corner(side_now);
      cb = corner(side_now);
    end else begin
      rb = nearby(ra);
      cb = nearby(ca);
    end
    send(ra, ca, rb, cb, $urandom_range(0, 1), $urandom_range(0, 3) == 0, gap);
    random_sent++;
  endtask

  initial begin
    int unsigned size_pick;
    int          jobs;
    bit          burst;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Default size after reset: single cell, full clear with out-of-range
    // corners, full fill with reversed corners, then word-edge stripes.
    send(1, 1, 1, 1, 1'b0, 1'b1, $urandom_range(0, 4));
    send(0, 0, 2047, 2047, 1'b0, 1'b0, $urandom_range(0, 4));
    send(1024, 1024, 1, 1, 1'b1, 1'b0, $urandom_range(0, 4));
    send(65, 64, 64, 65, 1'b0, 1'b0, $urandom_range(0, 4));
    send(1, 1024, 1024, 961, 1'b0, 1'b1, $urandom_range(0, 4));

    // Size 0 acts as a single cell.
    write_size(0);
    send(1, 1, 1, 1, 1'b0, 1'b1, $urandom_range(0, 4));
    send(0, 0, 0, 0, 1'b1, 1'b1, $urandom_range(0, 4));

    // Size above the maximum saturates.
    write_size(2047);
    send(500, 63, 700, 128, 1'b0, 1'b1, $urandom_range(0, 4));

    // One column past a word: partial first and last words.
    write_size(65);
    send(1, 64, 65, 65, 1'b0, 1'b0, $urandom_range(0, 4));
    send(2, 1, 3, 64, 1'b0, 1'b0, $urandom_range(0, 4));
    send(65, 65, 2, 2, 1'b1, 1'b0, $urandom_range(0, 4));
    send(33, 1, 40, 2047, 1'b0, 1'b1, $urandom_range(0, 4));

    write_size(1);
    send(2047, 2047, 1024, 1, 1'b0, 1'b1, $urandom_range(0, 4));

    write_size(128);
    send(1, 127, 128, 128, 1'b0, 1'b1, $urandom_range(0, 4));

    write_size(64);
    send(1, 1, 64, 64, 1'b0, 1'b0, $urandom_range(0, 4));
    send(64, 64, 64, 64, 1'b1, 1'b1, $urandom_range(0, 4));

    // Random jobs: a size write, then a handful of paints. Most sizes stay
    // small so paints are short; a few hit the extremes.
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       size_pick = $urandom_range(0, (1 << CFG_W) - 1);
        1:       size_pick = GRID_MAX;
        2:       size_pick = $urandom_range(0, 3);
        default: size_pick = $urandom_range(4, 130);
      endcase
      write_size(size_pick);
      burst = ($urandom_range(0, 2) == 0);
      jobs  = $urandom_range(4, 12);
      repeat (jobs) begin
        // Now and then drain every pending count before the next paint.
        if ($urandom_range(0, 9) == 0) settle();
        random_item(burst ? 0 : $urandom_range(0, 4));
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/bmrf_pkg.sv
src/bmrf_mem.sv
src/bmrf_cnt.sv
src/bitmap_rectangle_fill_count.sv
bench/bitmap_rectangle_fill_count_check.sv
bench/bitmap_rectangle_fill_count_test.sv
